// ----- rtl/core/fmts_pkg.sv -----
package fmts_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int LINE_CHUNK  = 999;

  localparam int BYTE_W      = 8;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int PLEN_W      = 5;
  localparam int REG_BYTES   = 2 * CFG_W / BYTE_W;
  localparam int RIDX_W      = $clog2(REG_BYTES);
  localparam int LINE_W      = 32;
  localparam int START_COL_W = 10;
  localparam int OUT_TDATA_W = ((LINE_W + START_COL_W + 7) / 8) * 8;

  // pattern length / cell index arithmetic
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int CMP_W = (LEN_W > PLEN_W) ? LEN_W : PLEN_W;

  // column counter and the wide compare domain
  localparam int COL_W     = $clog2(LINE_CHUNK + 1);
  localparam int WIDE_BASE = ((COL_W > CMP_W) ? COL_W : CMP_W) + 1;
  localparam int WIDE_W    = (WIDE_BASE > START_COL_W + 1) ? WIDE_BASE : START_COL_W + 1;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                   found;
    logic [LINE_W-1:0]      line_number;
    logic [START_COL_W-1:0] start_column;
  } result_t;

endpackage

// ----- rtl/core/first_match_text_search.sv -----
// Streaming first-match search: one text byte per beat, one beat per cycle, with no
// stall of its own. The byte window is a row of PATTERN_MAX cells that shift the
// line's newest byte in and compare it against the matching pattern byte in the same
// cycle; the AND of the cell compares, the column count and the line count settle the
// result, which is registered in the output buffer before the master side sees it.
// Results pass an output register and a one-deep skid stage, so the slave side keeps
// taking beats while a result waits; tready drops only when both are full. At most one
// result per stream: found with 1-based line and column when the first match inside
// one line completes, or not-found on the tlast beat. Lines end after a newline (which
// can be matched) or after LINE_CHUNK bytes. Pattern registers must be written only
// while the block is idle; the user is bound to this, the block does not enforce it.
module first_match_text_search
  import fmts_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // text in
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [BYTE_W-1:0]      s_axis_tdata_i,   // [7:0] text_byte
  input  logic                   s_axis_tuser_i,   // [0] byte_present
  input  logic                   s_axis_tlast_i,   // end_of_text
  // result out
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // [31:0] line_number, [41:32] start_column
  output logic                   m_axis_tuser_o    // [0] found
);

  logic [CFG_W-1:0]  pattern_low_q, pattern_high_q;
  logic [PLEN_W-1:0] pattern_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_low_q    <= '0;
      pattern_high_q   <= '0;
      pattern_length_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PATTERN_LOW:    pattern_low_q    <= cfg_data_i;
        REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data_i;
        REG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [2*CFG_W-1:0] pat_all;
  logic [BYTE_W-1:0]  pat_arr [REG_BYTES];
  logic [CMP_W-1:0]   plen_ext, len_eff;

  assign pat_all  = {pattern_high_q, pattern_low_q};
  assign plen_ext = CMP_W'(pattern_length_q);
  assign len_eff  = (plen_ext > CMP_W'(PATTERN_MAX)) ? CMP_W'(PATTERN_MAX) : plen_ext;

  always_comb begin
    for (int k = 0; k < REG_BYTES; k++) begin
      pat_arr[k] = pat_all[k*BYTE_W +: BYTE_W];
    end
  end

  logic                   s_accept, take, res_valid, buf_ready;
  logic                   line_open_q, match_seen_q;
  logic [COL_W-1:0]       bil_q, bil_base, bil_new;
  logic [LINE_W-1:0]      line_count_q, lc_new;
  logic [WIDE_W-1:0]      bil_w, len_w, col_w;
  logic                   len_zero, all_eq, hit, line_end;
  logic [PATTERN_MAX-1:0] eq;
  logic [BYTE_W-1:0]      win [PATTERN_MAX];
  result_t                res, m_res;

  assign s_axis_tready_o = buf_ready;
  assign s_accept        = s_axis_tvalid_i && buf_ready;
  assign take            = s_accept && s_axis_tuser_i && !match_seen_q;

  // cell j holds window byte j (newest at 0) and checks it against
  // pattern byte len-1-j
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [CMP_W-1:0]  idx;
    logic [BYTE_W-1:0] pat_b;
    logic              active;
    logic [BYTE_W-1:0] feed;

    assign active = CMP_W'(j) < len_eff;
    assign idx    = len_eff - CMP_W'(j) - CMP_W'(1);
    assign pat_b  = (idx < CMP_W'(REG_BYTES)) ? pat_arr[idx[RIDX_W-1:0]] : '0;

    if (j == 0) begin : g_head
      assign feed = s_axis_tdata_i;
    end else begin : g_link
      assign feed = win[j-1];
    end

    fmts_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (take),
      .byte_i     (feed),
      .pat_byte_i (pat_b),
      .active_i   (active),
      .byte_o     (win[j]),
      .eq_o       (eq[j])
    );
  end

  assign bil_base = line_open_q ? bil_q : '0;
  assign bil_new  = bil_base + COL_W'(1);
  assign lc_new   = (line_open_q || (line_count_q == '1)) ? line_count_q
                                                          : line_count_q + LINE_W'(1);
  assign bil_w    = WIDE_W'(bil_new);
  assign len_w    = WIDE_W'(len_eff);
  assign len_zero = (len_eff == '0);
  assign all_eq   = &eq;
  assign hit      = len_zero || ((bil_w >= len_w) && all_eq);
  assign col_w    = len_zero ? WIDE_W'(1) : (bil_w - len_w + WIDE_W'(1));
  assign line_end = (s_axis_tdata_i == NEWLINE_BYTE) || (bil_w >= WIDE_W'(LINE_CHUNK));

  assign res_valid = s_accept && ((take && hit) || (s_axis_tlast_i && !match_seen_q));

  always_comb begin
    res.found        = take && hit;
    res.line_number  = res.found ? lc_new : '0;
    res.start_column = res.found ? col_w[START_COL_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_open_q  <= 1'b0;
      match_seen_q <= 1'b0;
      bil_q        <= '0;
      line_count_q <= '0;
    end else if (s_accept) begin
      if (s_axis_tlast_i) begin
        line_open_q  <= 1'b0;
        match_seen_q <= 1'b0;
        bil_q        <= '0;
        line_count_q <= '0;
      end else if (take) begin
        line_open_q  <= !line_end;
        bil_q        <= bil_new;
        line_count_q <= lc_new;
        if (hit) begin
          match_seen_q <= 1'b1;
        end
      end
    end
  end

  fmts_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (buf_ready),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_res_o     (m_res)
  );

  assign m_axis_tuser_o = m_res.found;
  assign m_axis_tdata_o = OUT_TDATA_W'({m_res.start_column, m_res.line_number});

endmodule

// ----- rtl/core/fmts_cell.sv -----
module fmts_cell
  import fmts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [BYTE_W-1:0] pat_byte_i,
  input  logic              active_i,
  output logic [BYTE_W-1:0] byte_o,
  output logic              eq_o
);

  logic [BYTE_W-1:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // compare against the byte that lands here on this shift
  assign eq_o   = !active_i || (byte_i == pat_byte_i);
  assign byte_o = byte_q;

endmodule

// ----- rtl/core/fmts_out_buf.sv -----
module fmts_out_buf
  import fmts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t m_res_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_fire;

  assign out_fire = out_valid_q && m_ready_i;
  assign ready_o  = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (res_valid_i) begin
      if (!out_valid_q || out_fire) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_q;

endmodule

// ----- rtl/core/fmts_checker.sv -----
module fmts_checker
  import fmts_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                   m_axis_tuser_o
);

  // not-found beat carries all-zero position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("not-found beat with nonzero position");

  // a found beat always names a real line and column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tdata_o[LINE_W-1:0] != '0 &&
      m_axis_tdata_o[LINE_W +: START_COL_W] != '0)
    else $error("found beat with zero line or column");

  // column never exceeds the line chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      32'(m_axis_tdata_o[LINE_W +: START_COL_W]) <= 32'(LINE_CHUNK))
    else $error("column beyond line chunk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

endmodule

bind first_match_text_search fmts_checker u_fmts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ----- tb/testbench.sv -----
module testbench;
  import fmts_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              byte_present;
    logic              end_of_text;
  } text_beat_t;

  logic                   clk;
  logic                   rst_ni;
  logic                   cfg_we_i;
  cfg_reg_e               cfg_index_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [BYTE_W-1:0]      s_axis_tdata_i;
  logic                   s_axis_tuser_i;
  logic                   s_axis_tlast_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  first_match_text_search dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // stimulus and expected results
  text_beat_t  pending_text[$];
  result_t     due_results[$];
  int unsigned beats_queued;
  int unsigned beats_taken;
  int unsigned mismatches;

  // driver / receiver control
  bit          text_taken;
  int unsigned text_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_request;
  bit          calm;
  text_beat_t  next_beat;

  // register mirror
  logic [CFG_W-1:0]  pat_lo;
  logic [CFG_W-1:0]  pat_hi;
  logic [PLEN_W-1:0] pat_len;

  // search state mirror
  logic [BYTE_W-1:0] win_bytes [PATTERN_MAX];
  int unsigned       col_count;
  logic [LINE_W-1:0] line_total;
  bit                in_line;
  bit                hit_done;

  // pattern used for planting matches into random text
  logic [2*CFG_W-1:0] plant_bytes;
  int unsigned        plant_len;

  text_beat_t mon_beat;
  result_t    got_res;
  result_t    want_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] pattern_at(int unsigned k);
    logic [2*CFG_W-1:0] all;
    all = {pat_hi, pat_lo};
    return all[8*k +: 8];
  endfunction

  function automatic void clear_search();
    foreach (win_bytes[i]) win_bytes[i] = '0;
    col_count  = 0;
    line_total = '0;
    in_line    = 1'b0;
    hit_done   = 1'b0;
  endfunction

  // advance the search by one accepted beat, queue what the block must report
  function automatic void scan_beat(text_beat_t b);
    int unsigned len;
    int unsigned column;
    bit          hit;
    result_t     r;
    len = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    hit = 1'b0;
    column = 0;
    if (b.byte_present && !hit_done) begin
      if (!in_line) begin
        in_line = 1'b1;
        col_count = 0;
        foreach (win_bytes[i]) win_bytes[i] = '0;
        if (line_total != '1) line_total++;
      end
      for (int i = PATTERN_MAX - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
      win_bytes[0] = b.text_byte;
      col_count++;
      if (len == 0) begin
        hit = 1'b1;
        column = 1;
      end else if (col_count >= len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++)
          if (win_bytes[len-1-i] != pattern_at(i)) hit = 1'b0;
        column = col_count - len + 1;
      end
      // newline stays in its line; long lines are cut into chunks
      if (b.text_byte == NEWLINE_BYTE || col_count >= LINE_CHUNK) in_line = 1'b0;
      if (hit) begin
        hit_done = 1'b1;
        r.found = 1'b1;
        r.line_number = line_total;
        r.start_column = column[START_COL_W-1:0];
        due_results.push_back(r);
      end
    end
    if (b.end_of_text) begin
      if (!hit_done) begin
        r = '0;
        due_results.push_back(r);
      end
      clear_search();
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
  endtask

  // monitor: mirrors register writes, predicts on input beats, checks output beats
  always @(posedge clk) begin
    if (!rst_ni) begin
      text_taken = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PATTERN_LOW:    pat_lo = cfg_data_i;
          REG_PATTERN_HIGH:   pat_hi = cfg_data_i;
          REG_PATTERN_LENGTH: pat_len = cfg_data_i[PLEN_W-1:0];
          default: ;
        endcase
      end
      text_taken = s_axis_tvalid_i && s_axis_tready_o;
      if (text_taken) begin
        mon_beat.text_byte = s_axis_tdata_i;
        mon_beat.byte_present = s_axis_tuser_i;
        mon_beat.end_of_text = s_axis_tlast_i;
        scan_beat(mon_beat);
        beats_taken++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_res.found = m_axis_tuser_o;
        got_res.line_number = m_axis_tdata_o[LINE_W-1:0];
        got_res.start_column = m_axis_tdata_o[LINE_W +: START_COL_W];
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result beat, line", 64'(got_res.line_number), 64'(0));
        end else begin
          want_res = due_results.pop_front();
          if (got_res.found !== want_res.found)
            report_mismatch("found", 64'(got_res.found), 64'(want_res.found));
          if (got_res.line_number !== want_res.line_number)
            report_mismatch("line_number", 64'(got_res.line_number),
                            64'(want_res.line_number));
          if (got_res.start_column !== want_res.start_column)
            report_mismatch("start_column", 64'(got_res.start_column),
                            64'(want_res.start_column));
        end
      end
    end
  end

  // driver: one text beat per handshake, random gaps between beats
  always @(negedge clk) begin
    if (!s_axis_tvalid_i || text_taken) begin
      if (text_gap != 0) begin
        text_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_text.size() != 0) begin
        next_beat = pending_text.pop_front();
        s_axis_tdata_i  <= next_beat.text_byte;
        s_axis_tuser_i  <= next_beat.byte_present;
        s_axis_tlast_i  <= next_beat.end_of_text;
        s_axis_tvalid_i <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) text_gap = $urandom_range(1, 16);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold to back the block up
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = 300;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic add_beat(logic [BYTE_W-1:0] b, bit present, bit last);
    text_beat_t t;
    t.text_byte = b;
    t.byte_present = present;
    t.end_of_text = last;
    pending_text.push_back(t);
    beats_queued++;
  endtask

  task automatic add_line(string s, bit close);
    for (int i = 0; i < s.len(); i++) add_beat(s[i], 1'b1, close && i == s.len() - 1);
  endtask

  function automatic logic [2*CFG_W-1:0] pack_text(string s);
    logic [2*CFG_W-1:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 16; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  // mostly a two-letter alphabet with some newlines, so matches are common
  function automatic logic [BYTE_W-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return BYTE_W'($urandom_range(0, 255));
    if (r < 3) return NEWLINE_BYTE;
    return ($urandom_range(0, 1) != 0) ? 8'h61 : 8'h62;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic load_pattern(logic [2*CFG_W-1:0] bytes, logic [PLEN_W-1:0] len);
    logic [CFG_W-1:0] w;
    w = {$urandom, $urandom};
    w[PLEN_W-1:0] = len;  // upper bits are don't-care for the length register
    write_reg(REG_PATTERN_LOW, bytes[CFG_W-1:0]);
    write_reg(REG_PATTERN_HIGH, bytes[2*CFG_W-1:CFG_W]);
    write_reg(REG_PATTERN_LENGTH, w);
    plant_bytes = bytes;
    plant_len = (len > PATTERN_MAX) ? PATTERN_MAX : len;
  endtask

  // wait until every beat is in and every result out, then let the pipe drain
  task automatic settle();
    while (beats_taken != beats_queued || due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_pattern();
    logic [2*CFG_W-1:0] p;
    int unsigned        r;
    int unsigned        len;
    r = $urandom_range(0, 7);
    for (int k = 0; k < 16; k++) p[8*k +: 8] = pick_byte();
    case (r)
      0: len = 0;
      1: begin
        p = {$urandom, $urandom, $urandom, $urandom};
        len = $urandom_range(0, 31);
      end
      2: len = PATTERN_MAX;
      default: len = $urandom_range(1, 4);
    endcase
    load_pattern(p, PLEN_W'(len));
  endtask

  task automatic random_document();
    logic [BYTE_W-1:0] doc[$];
    int unsigned       n;
    int unsigned       at;
    bit                close_on_byte;
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
    for (int i = 0; i < n; i++) doc.push_back(pick_byte());
    if (plant_len != 0 && n >= plant_len && $urandom_range(0, 1) != 0) begin
      at = $urandom_range(0, n - plant_len);
      for (int k = 0; k < plant_len; k++) doc[at+k] = plant_bytes[8*k +: 8];
    end
    close_on_byte = (n != 0) && ($urandom_range(0, 1) != 0);
    foreach (doc[i]) begin
      if ($urandom_range(0, 19) == 0) add_beat(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
      add_beat(doc[i], 1'b1, close_on_byte && i == n - 1);
    end
    if (!close_on_byte) add_beat(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic random_phase(int unsigned target);
    int unsigned start;
    start = beats_queued;
    while (beats_queued - start < target) begin
      settle();
      random_pattern();
      repeat ($urandom_range(3, 8)) random_document();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_PATTERN_LOW;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    pat_lo          = '0;
    pat_hi          = '0;
    pat_len         = '0;
    plant_bytes     = '0;
    plant_len       = 0;
    text_gap        = 0;
    stall_left      = 0;
    hold_left       = 0;
    hold_request    = 1'b0;
    calm            = 1'b0;
    clear_search();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // empty pattern after reset: hit on first byte, rest of stream ignored
    add_beat(8'h5A, 1'b0, 1'b0);
    add_line("qr", 1'b1);
    // stream without any byte
    add_beat(8'hA5, 1'b0, 1'b1);

    // newline inside the pattern, match completes on the end beat
    settle();
    load_pattern(pack_text("ab\n"), PLEN_W'(3));
    add_line("b\nab\n", 1'b1);

    // pattern spans a newline: never matches
    settle();
    load_pattern(pack_text("b\nc"), PLEN_W'(3));
    add_line("ab\ncd", 1'b0);
    add_beat(8'h00, 1'b0, 1'b1);

    // all-ones pattern, length above the maximum clamps to 16
    settle();
    load_pattern('1, PLEN_W'(31));
    repeat (16) add_beat(8'hFF, 1'b1, 1'b0);
    add_beat(8'h00, 1'b0, 1'b1);

    // chunk boundary: pattern split across the cut, then one ending on column 999
    settle();
    load_pattern(pack_text("xyz"), PLEN_W'(3));
    repeat (997) add_beat(8'h61, 1'b1, 1'b0);
    add_line("xyzxyz", 1'b0);
    add_beat(8'h00, 1'b0, 1'b1);
    repeat (996) add_beat(8'h61, 1'b1, 1'b0);
    add_line("xyz", 1'b1);

    random_phase(400);

    // back-pressure: receiver holds while short streams keep producing results
    settle();
    load_pattern(pack_text("ab"), PLEN_W'(2));
    hold_request = 1'b1;
    repeat (12)
      for (int k = 0; k < 3; k++)
        add_beat(($urandom_range(0, 1) != 0) ? 8'h61 : 8'h62, 1'b1, k == 2);

    settle();
    calm = 1'b1;
    random_phase(60);

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("first_match_text_search test passed");
    end else begin
      $display("first_match_text_search test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("first_match_text_search test failed");
    $finish;
  end

endmodule
